### rtl/kepler_bisection_solver_unit_macros.svh
// Assertion macros shared by the Kepler bisection solver RTL.
`ifndef KEPLER_BISECTION_SOLVER_UNIT_MACROS_SVH
`define KEPLER_BISECTION_SOLVER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define KBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define KBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/kbs_pkg.sv
// Package: widths, fixed-point constants, arctangent table and item type of the solver.
package kbs_pkg;

	localparam int FRAC_W    = 32;
	localparam int ITERS     = 32;
	localparam int STAGES    = FRAC_W + 2;
	localparam int ECC_W     = 32;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 35;
	localparam int OUT_BYTES = (OUT_W + 7) / 8;
	localparam int TDATA_W   = OUT_BYTES * 8;
	localparam int ANG_W     = FRAC_W + 4;
	localparam int R_W       = FRAC_W + 2;
	localparam int RED_W     = IN_W + 2;
	localparam int RED_STEPS = 15;
	localparam int MAG_W     = FRAC_W + 1;
	localparam int EH_W      = ECC_W / 2;
	localparam int PRD_W     = EH_W + MAG_W;

	localparam longint unsigned PI_Q60   = 64'h3243F6A8885A308D;
	localparam longint unsigned GAIN_Q62 = 64'd2800459870029452954;

	function automatic longint unsigned rnd_q(longint unsigned v, int s);
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	// restoring long division, used only for elaboration-time constants
	function automatic longint unsigned udiv_q(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			q = {q[62:0], 1'b0};
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// arctan(2^-i) at 2^-62 by its series; i == 0 gives pi/4
	function automatic longint unsigned atan_q62(int i);
		longint sum;
		longint unsigned term;
		int ex;
		int k;
		sum = 0;
		if (i == 0) begin
			return PI_Q60;
		end
		for (k = 0; k < 64; k++) begin
			ex = i * (2 * k + 1);
			if (ex <= 62) begin
				term = udiv_q(64'd1 << (62 - ex), 64'(2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
		end
		return longint'(sum);
	endfunction

	typedef logic signed [ANG_W-1:0] ang_t;

	localparam longint unsigned PI_F      = rnd_q(PI_Q60, 60 - FRAC_W);
	localparam longint unsigned TWO_PI_F  = 2 * PI_F;
	localparam longint unsigned HALF_F    = rnd_q(PI_Q60, 61 - FRAC_W);
	localparam longint unsigned QUARTER_F = rnd_q(PI_Q60, 62 - FRAC_W);
	localparam longint unsigned GAIN_F    = rnd_q(GAIN_Q62, 62 - FRAC_W);

	localparam ang_t PI_A      = ang_t'(PI_F);
	localparam ang_t HALF_A    = ang_t'(HALF_F);
	localparam ang_t GAIN_A    = ang_t'(GAIN_F);
	localparam ang_t ONE_A     = ang_t'(64'd1 << FRAC_W);
	localparam ang_t NEG_ONE_A = -ONE_A;

	function automatic ang_t atan_f(int i);
		return ang_t'(rnd_q(atan_q62(i), 62 - FRAC_W));
	endfunction

	function automatic logic [FRAC_W-1:0] step_at(int it);
		return FRAC_W'(QUARTER_F >> it);
	endfunction

	typedef struct packed {
		logic [R_W-1:0] r;
		logic           flip;
		ang_t           est;
	} kbs_item_t;

endpackage

### rtl/kbs_reduce.sv
// Mean anomaly reduction into [0, 2*pi) by shifted compare/subtract stages, then mirror.
module kbs_reduce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [kbs_pkg::IN_W-1:0]  din,
	output logic                      out_valid,
	output kbs_pkg::kbs_item_t        out_item
);
	import kbs_pkg::*;

	localparam logic [RED_W-1:0] RED_OFF = RED_W'(TWO_PI_F << (RED_STEPS - 2));

	logic signed [RED_W-1:0] m_ext;
	logic        [RED_W-1:0] rem_s [0:RED_STEPS];
	logic                    v_s   [0:RED_STEPS];
	logic        [R_W:0]     rf;
	logic                    flip;
	logic                    fold_v_s1;
	kbs_item_t               fold_s1;

	// bias by a multiple of 2*pi so the floor modulo works on a positive value
	assign m_ext = RED_W'($signed(din));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= $unsigned(m_ext) + RED_OFF;
		end
	end

	for (genvar g = 0; g < RED_STEPS; g++) begin : g_sub
		localparam logic [RED_W-1:0] SUBV = RED_W'(TWO_PI_F << (RED_STEPS - 1 - g));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= (rem_s[g] >= SUBV) ? rem_s[g] - SUBV : rem_s[g];
			end
		end
	end

	assign rf   = rem_s[RED_STEPS][R_W:0];
	assign flip = rf > (R_W+1)'(PI_F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_v_s1 <= 1'b0;
		end else if (en) begin
			fold_v_s1 <= v_s[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1.flip <= flip;
			fold_s1.r    <= flip ? R_W'((R_W+1)'(TWO_PI_F) - rf) : R_W'(rf);
			fold_s1.est  <= HALF_A;
		end
	end

	assign out_valid = fold_v_s1;
	assign out_item  = fold_s1;

endmodule

### rtl/kbs_cordic.sv
// Sine of the current estimate: fold to [0, pi/2], then one CORDIC rotation per stage.
module kbs_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  kbs_pkg::kbs_item_t   in_item,
	output logic                 out_valid,
	output kbs_pkg::kbs_item_t   out_item,
	output kbs_pkg::ang_t        out_y,
	output logic                 out_neg
);
	import kbs_pkg::*;

	ang_t      a_abs;
	ang_t      a_fold;
	logic      v_s    [0:STAGES];
	ang_t      x_s    [0:STAGES];
	ang_t      y_s    [0:STAGES];
	ang_t      z_s    [0:STAGES];
	logic      neg_s  [0:STAGES];
	kbs_item_t item_s [0:STAGES];

	assign a_abs  = in_item.est[ANG_W-1] ? -in_item.est : in_item.est;
	assign a_fold = (a_abs > HALF_A) ? PI_A - a_abs : a_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= GAIN_A;
			y_s[0]    <= '0;
			z_s[0]    <= a_fold;
			neg_s[0]  <= in_item.est[ANG_W-1];
			item_s[0] <= in_item;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam ang_t ATN = atan_f(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATN;
				end
				neg_s[i+1]  <= neg_s[i];
				item_s[i+1] <= item_s[i];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_item  = item_s[STAGES];
	assign out_y     = y_s[STAGES];
	assign out_neg   = neg_s[STAGES];

endmodule

### rtl/kbs_iter.sv
// One bisection step: sine, e*sin product, compare against M and move the estimate.
module kbs_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [kbs_pkg::FRAC_W-1:0] step,
	input  logic [kbs_pkg::ECC_W-1:0]  ecc,
	input  logic                       in_valid,
	input  kbs_pkg::kbs_item_t         in_item,
	output logic                       out_valid,
	output kbs_pkg::kbs_item_t         out_item
);
	import kbs_pkg::*;

	logic                   c_v;
	kbs_item_t              c_item;
	ang_t                   c_y;
	logic                   c_neg;
	ang_t                   ys;
	ang_t                   ys_abs;
	logic [PRD_W:0]         psum;
	logic [PRD_W-EH_W:0]    p;
	ang_t                   prod;
	logic signed [ANG_W:0]  rx;
	ang_t                   est_nx;

	logic                   v_s1, v_s2, v_s3, v_s4;
	kbs_item_t              item_s1, item_s2, item_s3, item_s4;
	logic [MAG_W-1:0]       mag_s1;
	logic                   sneg_s1, sneg_s2;
	logic [PRD_W-1:0]       ph_s2, pl_s2;
	logic signed [ANG_W:0]  m1_s3;

	kbs_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_valid (c_v),
		.out_item  (c_item),
		.out_y     (c_y),
		.out_neg   (c_neg)
	);

	assign ys     = (c_y > ONE_A) ? ONE_A : ((c_y < NEG_ONE_A) ? NEG_ONE_A : c_y);
	assign ys_abs = ys[ANG_W-1] ? -ys : ys;

	// e*|sin| in two 16-bit halves of e, truncated
	assign psum = {1'b0, ph_s2} + (PRD_W+1)'(pl_s2 >> EH_W);
	assign p    = psum[PRD_W:EH_W];
	assign prod = sneg_s2 ? -ang_t'(p) : ang_t'(p);
	assign rx   = $signed({{(ANG_W+1-R_W){1'b0}}, item_s3.r});

	// equal: estimate kept
	assign est_nx = (rx > m1_s3) ? item_s3.est + ang_t'(step) :
		((rx < m1_s3) ? item_s3.est - ang_t'(step) : item_s3.est);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= c_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= c_item;
			mag_s1  <= MAG_W'(ys_abs);
			sneg_s1 <= (ys != '0) && (c_neg ^ ys[ANG_W-1]);

			item_s2 <= item_s1;
			sneg_s2 <= sneg_s1;
			ph_s2   <= PRD_W'(ecc[ECC_W-1:EH_W]) * PRD_W'(mag_s1);
			pl_s2   <= PRD_W'(ecc[EH_W-1:0]) * PRD_W'(mag_s1);

			item_s3 <= item_s2;
			m1_s3   <= {item_s2.est[ANG_W-1], item_s2.est} - {prod[ANG_W-1], prod};

			item_s4.r    <= item_s3.r;
			item_s4.flip <= item_s3.flip;
			item_s4.est  <= est_nx;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

endmodule

### rtl/kbs_out.sv
// Output register with skid entry; applies the mirror sign and drives the result stream.
`include "kepler_bisection_solver_unit_macros.svh"

module kbs_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  kbs_pkg::kbs_item_t          in_item,
	output logic                        en,
	output logic                        tvalid,
	input  logic                        tready,
	output logic [kbs_pkg::TDATA_W-1:0] tdata
);
	import kbs_pkg::*;

	kbs_pkg::ang_t    e_signed;
	logic [OUT_W-1:0] res;
	logic             main_v_q, skid_v_q;
	logic [OUT_W-1:0] main_q, skid_q;
	logic             load_in_main, load_in_skid, load_skid_main;

	assign e_signed = in_item.flip ? -in_item.est : in_item.est;
	assign res      = e_signed[OUT_W-1:0];

	// pipeline advances whenever the skid entry is free
	assign en             = !skid_v_q;
	assign load_skid_main = skid_v_q && tready;
	assign load_in_main   = !skid_v_q && in_valid && (!main_v_q || tready);
	assign load_in_skid   = !skid_v_q && in_valid && main_v_q && !tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_skid_main) begin
				skid_v_q <= 1'b0;
			end else if (load_in_skid) begin
				skid_v_q <= 1'b1;
			end
			if (load_in_main) begin
				main_v_q <= 1'b1;
			end else if (!skid_v_q && tready) begin
				main_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_skid_main) begin
			main_q <= skid_q;
		end else if (load_in_main) begin
			main_q <= res;
		end
		if (load_in_skid) begin
			skid_q <= res;
		end
	end

	assign tvalid = main_v_q;
	assign tdata  = TDATA_W'(main_q);

	`KBS_ASSERT_IMP(a_skid_behind_main, skid_v_q, main_v_q, "skid entry held with empty output register")
	`KBS_ASSERT_NXT(a_skid_drains, skid_v_q && tready, main_v_q && !skid_v_q, "skid entry not moved on transfer")
	`KBS_ASSERT_IMP(a_no_double_load, load_in_main || load_in_skid, !(load_in_main && load_in_skid), "result loaded twice")

endmodule

### rtl/kepler_bisection_solver_unit.sv
// Top level: Kepler equation solver by bisection, fully pipelined.
//
//  channel   | signals                              | contents
//  ----------+--------------------------------------+---------------------------------------
//  s_axis    | s_axis_tvalid/tready, tdata[47:0]    | mean_anomaly, signed, 32 fraction bits
//  m_axis    | m_axis_tvalid/tready, tdata[39:0]    | eccentric_anomaly [34:0], zero above
//  cfg       | cfg_valid/cfg_ready, cfg_data[31:0]  | eccentricity, unsigned 2^-32 units
//
// One item per cycle while the skid entry is free: reduction, then 32 bisection steps (34 CORDIC
// rotations plus fold, saturate, multiply, subtract, update), then the output register.
// A result waiting at m_axis parks in a skid entry; the pipeline stops only while it is full.
// Reset clears valid bits and sets eccentricity to zero; cfg_ready is always high.
`include "kepler_bisection_solver_unit_macros.svh"

module kepler_bisection_solver_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [kbs_pkg::IN_W-1:0]    s_axis_tdata,  // [47:0] mean_anomaly
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [kbs_pkg::TDATA_W-1:0] m_axis_tdata,  // [34:0] eccentric_anomaly
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kbs_pkg::ECC_W-1:0]   cfg_data       // [31:0] eccentricity
);
	import kbs_pkg::*;

	logic             en;
	logic [ECC_W-1:0] ecc_q;
	logic             red_v;
	kbs_item_t        red_item;
	logic             it_v    [0:ITERS];
	kbs_item_t        it_item [0:ITERS];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			ecc_q <= cfg_data;
		end
	end

	kbs_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.din       (s_axis_tdata),
		.out_valid (red_v),
		.out_item  (red_item)
	);

	assign it_v[0]    = red_v;
	assign it_item[0] = red_item;

	for (genvar g = 0; g < ITERS; g++) begin : g_iter
		kbs_iter u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (step_at(g)),
			.ecc       (ecc_q),
			.in_valid  (it_v[g]),
			.in_item   (it_item[g]),
			.out_valid (it_v[g+1]),
			.out_item  (it_item[g+1])
		);
	end

	kbs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (it_v[ITERS]),
		.in_item  (it_item[ITERS]),
		.en       (en),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata)
	);

	`KBS_ASSERT_IMP(a_reduced_in_range, red_v, red_item.r <= R_W'(PI_F), "reduced anomaly above pi")
	`KBS_ASSERT_IMP(a_mirror_nonzero, red_v && red_item.flip, red_item.r != '0, "mirrored anomaly is zero")
	`KBS_ASSERT_NXT(a_hold_on_stall, !en, $stable(it_v[ITERS]) && $stable(it_item[ITERS]), "pipeline moved while stalled")

endmodule

### tb/tb_kepler_bisection_solver_unit.sv
// Testbench for the Kepler bisection solver: directed table plus random angles, checked against a predictor.
`timescale 1ns / 1ps

module tb_kepler_bisection_solver_unit;
	import kbs_pkg::*;

	localparam int NPHASE = 6;
	localparam int RAND_PER_PHASE = 200;
	localparam int TAIL_CYCLES = 1300;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [ECC_W-1:0] cfg_data;

	kepler_bisection_solver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// fixed-point constants of the solver, QF with F = FRAC_W
	longint pi_q, two_pi_q, half_pi_q, quarter_pi_q, gain_q;
	longint arctan_q [STAGES];
	logic [ECC_W-1:0] ecc_shadow;
	logic [OUT_W-1:0] anomaly_q [$];
	int errors;

	typedef struct {
		logic [IN_W-1:0] mean;
		bit known;
		logic [OUT_W-1:0] anomaly;
	} angle_row_t;

	angle_row_t angle_rows [$];

	function automatic longint round_q(longint unsigned v, int s);
		return longint'((v + (64'd1 << (s - 1))) >> s);
	endfunction

	function automatic longint arctan_series(int i);
		longint acc;
		longint unsigned term;
		int ex;
		acc = 0;
		if (i == 0) begin
			return longint'(PI_Q60);
		end
		for (int k = 0; k < 64; k++) begin
			ex = i * (2 * k + 1);
			if (ex <= 62) begin
				term = (64'd1 << (62 - ex)) / longint'(2 * k + 1);
				acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
		end
		return acc;
	endfunction

	function automatic longint sine_q(longint a);
		longint x, y, z, dx, dy;
		longint one;
		bit neg;
		one = longint'(1) << FRAC_W;
		neg = 0;
		x = gain_q;
		y = 0;
		if (a < 0) begin
			a = -a;
			neg = 1;
		end
		if (a > half_pi_q) begin
			a = pi_q - a;
		end
		z = a;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_q[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_q[i];
			end
		end
		if (y > one) y = one;
		if (y < -one) y = -one;
		return neg ? -y : y;
	endfunction

	function automatic logic [OUT_W-1:0] solve_anomaly(logic [IN_W-1:0] mean,
			logic [ECC_W-1:0] ecc);
		longint m, r, est, stp, s, prod, m1;
		longint unsigned mag, p, eh, el;
		bit flip;
		m = longint'(signed'(mean));
		r = m % two_pi_q;
		if (r < 0) r = r + two_pi_q;
		flip = r > pi_q;
		if (flip) r = two_pi_q - r;
		eh = longint'(ecc) >> 16;
		el = longint'(ecc) & 64'hFFFF;
		est = half_pi_q;
		stp = quarter_pi_q;
		for (int it = 0; it < ITERS; it++) begin
			s = sine_q(est);
			mag = (s < 0) ? -s : s;
			p = ((eh * mag) + ((el * mag) >> 16)) >> 16;
			prod = (s < 0) ? -longint'(p) : longint'(p);
			m1 = est - prod;
			if (r > m1) est = est + stp;
			else if (r < m1) est = est - stp;
			stp = stp >> 1;
		end
		if (flip) est = -est;
		return est[OUT_W-1:0];
	endfunction

	initial clk = 1'b0;

	always #2 clk = ~clk;

	// receiver stall pattern: steps through four tready modes in turn
	int rx_cycle;
	always @(posedge clk) begin
		int mode;
		rx_cycle <= rx_cycle + 1;
		mode = (rx_cycle / 256) % 4;
		case (mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= (rx_cycle % 7) < 4;
			2: m_axis_tready <= ($urandom_range(0, 9) < 6);
			default: m_axis_tready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (anomaly_q.size() == 0) begin
				$error("unexpected transfer: eccentric_anomaly %h", m_axis_tdata[OUT_W-1:0]);
				errors++;
			end else begin
				want = anomaly_q.pop_front();
				if (m_axis_tdata[OUT_W-1:0] !== want) begin
					$error("eccentric_anomaly expected %h actual %h",
						want, m_axis_tdata[OUT_W-1:0]);
					errors++;
				end
			end
		end
	end

	task automatic write_ecc(logic [ECC_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		ecc_shadow = value;
		cfg_valid <= 1'b0;
	endtask

	int burst_left;

	task automatic send_angle(logic [IN_W-1:0] mean, bit known, logic [OUT_W-1:0] typed);
		logic [OUT_W-1:0] want;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= mean;
		do @(posedge clk); while (!s_axis_tready);
		want = solve_anomaly(mean, ecc_shadow);
		if (known && typed !== want) begin
			$error("eccentric_anomaly table entry %h disagrees with predictor %h", typed, want);
			errors++;
		end
		anomaly_q.push_back(want);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [IN_W-1:0] random_angle();
		longint v;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			v = longint'({$urandom_range(0, 15), $urandom});
			if ($urandom_range(0, 1)) v = -v;
		end else if (pick < 8) begin
			v = ($urandom_range(0, 1) ? pi_q : two_pi_q) + longint'($urandom_range(0, 8)) - 4;
			if ($urandom_range(0, 1)) v = -v;
		end else begin
			v = longint'({$urandom, $urandom});
		end
		return v[IN_W-1:0];
	endfunction

	task automatic wait_drained();
		while (anomaly_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [ECC_W-1:0] ecc_plan [NPHASE];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		m_axis_tready = 1'b0;
		rx_cycle = 0;
		errors = 0;
		burst_left = 0;
		ecc_shadow = '0;

		pi_q = round_q(PI_Q60, 60 - FRAC_W);
		two_pi_q = 2 * pi_q;
		half_pi_q = round_q(PI_Q60, 61 - FRAC_W);
		quarter_pi_q = round_q(PI_Q60, 62 - FRAC_W);
		gain_q = round_q(GAIN_Q62, 62 - FRAC_W);
		for (int i = 0; i < STAGES; i++) arctan_q[i] = round_q(arctan_series(i), 62 - FRAC_W);

		// extremes, the pi boundary (not mirrored), just above pi, negatives, 2*pi wrap
		angle_rows = '{
			'{48'h0, 0, '0},
			'{48'h7FFF_FFFF_FFFF, 0, '0},
			'{48'h8000_0000_0000, 0, '0},
			'{48'hFFFF_FFFF_FFFF, 0, '0},
			'{48'h1, 0, '0},
			'{IN_W'(pi_q), 0, '0},
			'{IN_W'(pi_q + 1), 0, '0},
			'{IN_W'(pi_q - 1), 0, '0},
			'{IN_W'(-pi_q), 0, '0},
			'{IN_W'(two_pi_q), 0, '0},
			'{IN_W'(two_pi_q - 1), 0, '0},
			'{IN_W'(-two_pi_q), 0, '0},
			'{IN_W'(half_pi_q), 0, '0},
			'{IN_W'(-half_pi_q), 0, '0},
			'{IN_W'(quarter_pi_q), 0, '0},
			'{48'h5555_5555_5555, 0, '0},
			'{48'hAAAA_AAAA_AAAA, 0, '0},
			'{IN_W'(longint'(1) << FRAC_W), 0, '0}
		};

		ecc_plan[0] = 32'h0;
		ecc_plan[1] = 32'hFFFF_FFFF;
		ecc_plan[2] = 32'h8000_0000;
		ecc_plan[3] = $urandom;
		ecc_plan[4] = 32'h1;
		ecc_plan[5] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NPHASE; ph++) begin
			write_ecc(ecc_plan[ph]);
			if (ph < 2) begin
				foreach (angle_rows[i])
					send_angle(angle_rows[i].mean, angle_rows[i].known, angle_rows[i].anomaly);
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) send_angle(random_angle(), 0, '0);
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && anomaly_q.size() == 0) begin
			$display("tb_kepler_bisection_solver_unit: PASS");
		end else begin
			$display("tb_kepler_bisection_solver_unit: FAIL");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_kepler_bisection_solver_unit: FAIL");
		$finish;
	end

endmodule
